[hdl/qdd_pkg.sv]
`default_nettype none

package qdd_pkg;

  // Number of encoder lanes built. Range 1 to 8; only the first MASK_WIDTH
  // lanes have pins and can report a detent.
  localparam int ENCODER_COUNT = 4;

  localparam int MASK_WIDTH      = 4;
  localparam int REG_COUNT       = 4;
  localparam int RES_WIDTH       = 7;
  localparam int ACC_WIDTH       = 8;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int REG_SEL_WIDTH   = $clog2(REG_COUNT);
  // Wide enough to hold accumulator plus step, and minus the resolution.
  localparam int SUM_WIDTH       = ACC_WIDTH + 2;

  localparam logic [RES_WIDTH-1:0] RESET_RESOLUTION = RES_WIDTH'(4);

  // Step for each (previous pair, current pair) transition, index {prev, cur}.
  localparam logic signed [1:0] GRAY_STEP [16] = '{
    2'sb00, 2'sb11, 2'sb01, 2'sb00,
    2'sb01, 2'sb00, 2'sb00, 2'sb11,
    2'sb11, 2'sb00, 2'sb00, 2'sb01,
    2'sb00, 2'sb01, 2'sb11, 2'sb00
  };

  typedef struct packed {
    logic cw;
    logic ccw;
  } detent_t;

endpackage

`default_nettype wire

[hdl/qdd_lane.sv]
`default_nettype none

module qdd_lane (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           fire,
  input  wire logic                           primed,
  input  wire logic [1:0]                     pin_pair,
  input  wire logic [qdd_pkg::RES_WIDTH-1:0]  resolution,
  output qdd_pkg::detent_t                    flags
);

  logic [1:0]                               last_pair;
  logic signed [qdd_pkg::ACC_WIDTH-1:0]     acc;
  logic signed [qdd_pkg::ACC_WIDTH-1:0]     acc_next;
  logic signed [1:0]                        step;
  logic                                     moved;
  logic [qdd_pkg::RES_WIDTH-1:0]            res_eff;
  logic signed [qdd_pkg::SUM_WIDTH-1:0]     res_s;
  logic signed [qdd_pkg::SUM_WIDTH-1:0]     pos;
  logic signed [qdd_pkg::SUM_WIDTH-1:0]     pos_adj;
  logic                                     hit_cw;
  logic                                     hit_ccw;

  always_comb begin
    step    = qdd_pkg::GRAY_STEP[{last_pair, pin_pair}];
    moved   = primed && (pin_pair != last_pair) && (step != 2'sb00);
    res_eff = (resolution == '0) ? qdd_pkg::RES_WIDTH'(1) : resolution;
    res_s   = $signed({{(qdd_pkg::SUM_WIDTH - qdd_pkg::RES_WIDTH){1'b0}}, res_eff});
    pos     = qdd_pkg::SUM_WIDTH'(acc) + qdd_pkg::SUM_WIDTH'(step);
    hit_cw  = (pos >= res_s);
    hit_ccw = !hit_cw && (pos <= -res_s);
    if (hit_cw) begin
      pos_adj = pos - res_s;
    end else if (hit_ccw) begin
      pos_adj = pos + res_s;
    end else begin
      pos_adj = pos;
    end
    // One step past either end of the accumulator always crosses the
    // resolution, so the adjusted value fits the accumulator again.
    acc_next  = pos_adj[qdd_pkg::ACC_WIDTH-1:0];
    flags.cw  = moved && hit_cw;
    flags.ccw = moved && hit_ccw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pair <= 2'b00;
      acc       <= '0;
    end else if (fire) begin
      last_pair <= pin_pair;
      if (moved) begin
        acc <= acc_next;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    !primed |-> (!flags.cw && !flags.ccw))
    else $error("lane flagged a detent before the first scan was recorded");

endmodule

`default_nettype wire

[hdl/qdd_merge.sv]
`default_nettype none

module qdd_merge (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire qdd_pkg::detent_t                flags [qdd_pkg::ENCODER_COUNT],
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [qdd_pkg::MASK_WIDTH-1:0]       cw_mask,
  output logic [qdd_pkg::MASK_WIDTH-1:0]       ccw_mask
);

  logic [qdd_pkg::MASK_WIDTH-1:0] new_cw;
  logic [qdd_pkg::MASK_WIDTH-1:0] new_ccw;
  logic [qdd_pkg::MASK_WIDTH-1:0] skid_cw;
  logic [qdd_pkg::MASK_WIDTH-1:0] skid_ccw;
  logic                           skid_valid;
  logic                           in_fire;
  logic                           out_free;

  for (genvar i = 0; i < qdd_pkg::MASK_WIDTH; i++) begin : g_bit
    if (i < qdd_pkg::ENCODER_COUNT) begin : g_lane
      assign new_cw[i]  = flags[i].cw;
      assign new_ccw[i] = flags[i].ccw;
    end else begin : g_none
      assign new_cw[i]  = 1'b0;
      assign new_ccw[i] = 1'b0;
    end
  end

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        cw_mask  <= skid_cw;
        ccw_mask <= skid_ccw;
      end else begin
        cw_mask  <= new_cw;
        ccw_mask <= new_ccw;
      end
    end else if (in_fire) begin
      skid_cw  <= new_cw;
      skid_ccw <= new_ccw;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a beat while the output stage is empty");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((cw_mask & ccw_mask) == '0))
    else $error("an encoder reported both directions in one beat");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && in_fire) |=> (skid_valid && out_valid))
    else $error("beat accepted under stall was not parked in the skid stage");

endmodule

`default_nettype wire

[hdl/quadrature_detent_decoder_top.sv]
`default_nettype none

// Decoder for a bank of rotary encoders with a detent divider per encoder.
// Input channel: in_valid/in_ready carry one scan of the A and B pins, bit i
// of each field for encoder i. Output channel: out_valid/out_ready carry one
// beat per scan with the clockwise and counter-clockwise detent masks.
// Result beats are registered in the output register, and a new scan is taken
// every cycle while in_ready is high; all encoder lanes decode in parallel,
// each with one table lookup and one add and compare on its accumulator.
// When the receiver stalls, the output register holds its beat and one more
// scan is taken into a skid register; in_ready drops only while that skid
// register is full.
// The config port writes resolution_0..3 (index 0..3) at any edge with
// cfg_write_en high; other indexes are ignored. Write only while idle.
// Reset (synchronous, active high) sets all resolutions to 4, clears pin
// history and accumulators, and makes the first scan after it only record
// the pins and return empty masks.
module quadrature_detent_decoder_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write_en,
  input  wire logic [qdd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [qdd_pkg::RES_WIDTH-1:0]       cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [qdd_pkg::MASK_WIDTH-1:0]      phase_a_bits,
  input  wire logic [qdd_pkg::MASK_WIDTH-1:0]      phase_b_bits,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [qdd_pkg::MASK_WIDTH-1:0]           clockwise_mask,
  output logic [qdd_pkg::MASK_WIDTH-1:0]           counter_clockwise_mask
);

  logic [qdd_pkg::RES_WIDTH-1:0] resolution [qdd_pkg::REG_COUNT];
  logic                          primed;
  logic                          in_fire;
  qdd_pkg::detent_t              flags [qdd_pkg::ENCODER_COUNT];

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < qdd_pkg::REG_COUNT; r++) begin
        resolution[r] <= qdd_pkg::RESET_RESOLUTION;
      end
    end else if (cfg_write_en &&
                 (cfg_index < qdd_pkg::CFG_INDEX_WIDTH'(qdd_pkg::REG_COUNT))) begin
      resolution[cfg_index[qdd_pkg::REG_SEL_WIDTH-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (in_fire) begin
      primed <= 1'b1;
    end
  end

  for (genvar i = 0; i < qdd_pkg::ENCODER_COUNT; i++) begin : g_lane
    logic [1:0]                    pair;
    logic [qdd_pkg::RES_WIDTH-1:0] lane_res;

    // Lanes past the pin fields see idle pins and keep the reset resolution.
    if (i < qdd_pkg::MASK_WIDTH) begin : g_pins
      assign pair = {phase_a_bits[i], phase_b_bits[i]};
    end else begin : g_nopins
      assign pair = 2'b00;
    end

    if (i < qdd_pkg::REG_COUNT) begin : g_res
      assign lane_res = resolution[i];
    end else begin : g_nores
      assign lane_res = qdd_pkg::RESET_RESOLUTION;
    end

    qdd_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .fire       (in_fire),
      .primed     (primed),
      .pin_pair   (pair),
      .resolution (lane_res),
      .flags      (flags[i])
    );
  end

  qdd_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .flags     (flags),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cw_mask   (clockwise_mask),
    .ccw_mask  (counter_clockwise_mask)
  );

endmodule

`default_nettype wire
